[hw/rtl/rau_pkg.sv]
`timescale 1ns / 1ps
package rau_pkg;
  localparam int WIDTH = 32;

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_INC  = 3'd4;
  localparam logic [2:0] OP_SIMP = 3'd5;
  localparam logic [2:0] OP_EQ   = 3'd6;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZDEN = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;

  typedef struct packed {
    logic [2:0]              req_type;
    logic signed [WIDTH-1:0] a_num;
    logic signed [WIDTH-1:0] a_den;
    logic signed [WIDTH-1:0] b_num;
    logic signed [WIDTH-1:0] b_den;
  } rau_in_t;

  typedef struct packed {
    logic signed [WIDTH-1:0] res_num;
    logic signed [WIDTH-1:0] res_den;
    logic                    is_equal;
    logic [1:0]              status;
  } rau_out_t;
endpackage

[hw/rtl/rational_arithmetic_unit.sv]
`timescale 1ns / 1ps
// Rational ALU: one item (opcode and two signed fractions) in, one result out.
// start is taken when busy is low; busy then stays high until the result is
// shown on out_data for one cycle with out_valid high. The receiver cannot
// stall, so it must take the result in that cycle. Add, subtract, multiply
// and divide share one 32x32 multiplier that forms the products one a cycle;
// multiply and divide need one product fewer. Increment, equal, the unused
// opcode, a zero input denominator and division by zero go straight to the
// result. Simplify runs Euclid's algorithm on one shared restoring divider,
// plus two more divisions for the reduced fraction (the remainder steps
// number at most about 46 for 32-bit values).
module rational_arithmetic_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  rau_pkg::rau_in_t  in_data,
  output logic              busy,
  output logic              out_valid,
  output rau_pkg::rau_out_t out_data
);
  import rau_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_NORM = 4'd1;
  localparam logic [3:0] S_MUL  = 4'd2;
  localparam logic [3:0] S_EUC  = 4'd3;
  localparam logic [3:0] S_DIVN = 4'd4;
  localparam logic [3:0] S_DIVD = 4'd5;
  localparam logic [3:0] S_FIN  = 4'd6;
  localparam logic [3:0] S_DONE = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;

  localparam int DCW = $clog2(WIDTH + 1);

  logic [3:0]       state_r, state_nxt, ret_r, ret_nxt;
  logic [2:0]       op_r;
  logic [WIDTH-1:0] an_r, ad_r, bn_r, bd_r;
  logic [WIDTH-1:0] p_r [0:3];
  logic [2:0]       mstep_r;
  logic [WIDTH-1:0] x_r, y_r, g_r;
  // divider: quotient/dividend shift register, partial remainder
  logic [WIDTH-1:0] dq_r, dv_r;
  logic [WIDTH:0]   rem_r;
  logic [DCW-1:0]   dcnt_r;
  logic [WIDTH-1:0] rn_r, rd_r;
  logic [1:0]       st_r;
  logic             eq_r, ov_r;

  function automatic logic [WIDTH-1:0] nabs(input logic [WIDTH-1:0] v);
    nabs = v[WIDTH-1] ? (~v + 1'b1) : v;
  endfunction

  // shared multiplier operands, chosen by step
  logic [WIDTH-1:0] ma, mb, mprod;
  always_comb begin
    ma = an_r; mb = bd_r;
    case (mstep_r)
      3'd0: begin ma = an_r; mb = (op_r == OP_MUL) ? bn_r : bd_r; end
      3'd1: begin ma = bn_r; mb = ad_r; end
      3'd2: begin ma = ad_r; mb = (op_r == OP_DIV) ? bn_r : bd_r; end
      default: begin ma = an_r; mb = bd_r; end
    endcase
  end
  assign mprod = ma * mb;

  logic [WIDTH:0] rsh, rsub;
  assign rsh  = {rem_r[WIDTH-1:0], dq_r[WIDTH-1]};
  assign rsub = rsh - {1'b0, dv_r};

  logic [WIDTH-1:0] fn, fd;
  logic [1:0]       fst;
  logic             feq;
  logic             uses_b;
  assign uses_b = (op_r <= OP_DIV) || (op_r == OP_EQ);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= (state_r == S_DONE);
    end
  end

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    case (state_r)
      S_IDLE: if (start) state_nxt = S_NORM;
      S_NORM: begin
        if (ad_r == '0 || (uses_b && bd_r == '0)) state_nxt = S_FIN;
        else begin
          case (op_r)
            OP_ADD, OP_SUB, OP_MUL: state_nxt = S_MUL;
            OP_DIV: state_nxt = (bn_r == '0) ? S_FIN : S_MUL;
            OP_SIMP: state_nxt = (an_r == '0) ? S_FIN : S_EUC;
            default: state_nxt = S_FIN;
          endcase
        end
      end
      // multiply and divide skip step 1, so step 2 is always the last
      S_MUL: if (mstep_r == 3'd2) state_nxt = S_FIN;
      S_EUC: if (y_r == '0) state_nxt = S_DIVN;
             else begin state_nxt = S_DIV; ret_nxt = S_EUC; end
      S_DIVN: begin state_nxt = S_DIV; ret_nxt = S_DIVD; end
      S_DIVD: begin state_nxt = S_DIV; ret_nxt = S_FIN; end
      S_DIV: if (dcnt_r == DCW'(WIDTH)) state_nxt = ret_r;
      S_FIN: state_nxt = S_DONE;
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // result assembly
  always_comb begin
    logic [WIDTH-1:0] n, d;
    n = '0; d = {{(WIDTH-1){1'b0}}, 1'b1};
    fst = ST_OK; feq = 1'b0;
    if (ad_r == '0 || (uses_b && bd_r == '0)) fst = ST_ZDEN;
    else begin
      case (op_r)
        OP_ADD, OP_SUB: begin
          if (ad_r == bd_r) begin n = an_r + bn_r; d = ad_r; end
          else begin n = p_r[0] + p_r[1]; d = p_r[2]; end
        end
        OP_MUL: begin n = p_r[0]; d = p_r[2]; end
        OP_DIV: begin
          if (bn_r == '0) fst = ST_DIVZ;
          else begin n = p_r[0]; d = p_r[2]; end
        end
        OP_INC: begin n = an_r + ad_r; d = ad_r; end
        OP_SIMP: if (an_r != '0) begin n = rn_r; d = rd_r; end
        OP_EQ: feq = (an_r == bn_r) && (ad_r == bd_r);
        default: ;
      endcase
      if (d[WIDTH-1] && op_r != OP_SIMP && op_r != OP_INC) begin
        n = ~n + 1'b1; d = ~d + 1'b1;
      end
      if (fst == ST_OK && d == '0) fst = ST_ZDEN;
    end
    if (fst != ST_OK) begin n = '0; d = '0; feq = 1'b0; end
    fn = n; fd = d;
  end

  always_ff @(posedge clk) begin
    ret_r <= ret_nxt;
    case (state_r)
      S_IDLE: if (start) begin
        op_r    <= in_data.req_type;
        an_r    <= in_data.a_den[WIDTH-1] ? ~in_data.a_num + 1'b1 : in_data.a_num;
        ad_r    <= in_data.a_den[WIDTH-1] ? ~in_data.a_den + 1'b1 : in_data.a_den;
        bn_r    <= (in_data.b_den[WIDTH-1] ? ~in_data.b_num + 1'b1 : in_data.b_num);
        bd_r    <= in_data.b_den[WIDTH-1] ? ~in_data.b_den + 1'b1 : in_data.b_den;
      end
      S_NORM: begin
        if (op_r == OP_SUB) bn_r <= ~bn_r + 1'b1;
        mstep_r <= '0;
        x_r <= nabs(an_r);
        y_r <= nabs(ad_r);
      end
      S_MUL: begin
        p_r[mstep_r[1:0]] <= mprod;
        mstep_r <= (op_r >= OP_MUL && mstep_r == 3'd0) ? 3'd2 : mstep_r + 3'd1;
      end
      S_EUC: begin
        if (y_r == '0) g_r <= x_r;
        else begin
          dq_r <= x_r; dv_r <= y_r; rem_r <= '0; dcnt_r <= '0;
          x_r <= y_r;
        end
      end
      S_DIVN: begin dq_r <= nabs(an_r); dv_r <= g_r; rem_r <= '0; dcnt_r <= '0; end
      S_DIVD: begin
        rn_r <= an_r[WIDTH-1] ? ~dq_r + 1'b1 : dq_r;
        dq_r <= nabs(ad_r); dv_r <= g_r; rem_r <= '0; dcnt_r <= '0;
      end
      S_DIV: begin
        if (dcnt_r == DCW'(WIDTH)) begin
          if (ret_r == S_EUC) y_r <= rem_r[WIDTH-1:0];
          if (ret_r == S_FIN) rd_r <= ad_r[WIDTH-1] ? ~dq_r + 1'b1 : dq_r;
        end else begin
          dcnt_r <= dcnt_r + 1'b1;
          if (!rsub[WIDTH]) begin rem_r <= rsub; dq_r <= {dq_r[WIDTH-2:0], 1'b1}; end
          else begin rem_r <= rsh; dq_r <= {dq_r[WIDTH-2:0], 1'b0}; end
        end
      end
      S_FIN: begin rn_r <= fn; rd_r <= fd; st_r <= fst; eq_r <= feq; end
      default: ;
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_data  = '{res_num: rn_r, res_den: rd_r, is_equal: eq_r, status: st_r};

  a_res_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |=> out_valid) else $error("result strobe missed");
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == S_IDLE)) else $error("strobe while working");
  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (dcnt_r <= DCW'(WIDTH))) else $error("divider overrun");
endmodule

[tb/rational_arithmetic_unit_tb.sv]
`timescale 1ns / 1ps
module rational_arithmetic_unit_tb;
  import rau_pkg::*;

  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 10_000_000;
  localparam int unsigned NUM_RANDOM = 1130;

  logic     clk;
  logic     rst_n;
  logic     start;
  rau_in_t  in_data;
  logic     busy;
  logic     out_valid;
  rau_out_t out_data;

  rational_arithmetic_unit uut (
    .clk(clk), .rst_n(rst_n), .start(start), .in_data(in_data),
    .busy(busy), .out_valid(out_valid), .out_data(out_data)
  );

  typedef logic signed [WIDTH-1:0] word_t;

  // One directed row: the item, and optionally a hand-typed answer.
  typedef struct {
    rau_in_t  req;
    bit       typed;
    rau_out_t ans;
  } dir_row_t;

  rau_out_t    pending_results[$];
  int unsigned errors;
  int unsigned cycle_count;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Run watchdog: a cycle counter with a generous cap.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Make the denominator positive; the most negative value wraps to itself.
  function automatic void sign_fix(inout word_t n, inout word_t d);
    if (d[WIDTH-1]) begin
      n = -n;
      d = -d;
    end
  endfunction

  function automatic logic [WIDTH-1:0] mag(word_t v);
    return v[WIDTH-1] ? -v : v;
  endfunction

  function automatic rau_out_t rational_result(rau_in_t req);
    word_t an, ad, bn, bd, rn, rd;
    logic [WIDTH-1:0] x, y, r, g, q;
    logic eq;
    logic [1:0] st;
    bit uses_b;
    rau_out_t o;
    an = req.a_num; ad = req.a_den; bn = req.b_num; bd = req.b_den;
    sign_fix(an, ad);
    sign_fix(bn, bd);
    rn = 0; rd = 1; eq = 1'b0; st = ST_OK;
    uses_b = (req.req_type <= OP_DIV) || (req.req_type == OP_EQ);
    if (ad == 0 || (uses_b && bd == 0)) begin
      st = ST_ZDEN;
    end else begin
      if (req.req_type == OP_SUB) bn = -bn;
      case (req.req_type)
        OP_ADD, OP_SUB: begin
          if (ad == bd) begin
            rn = an + bn; rd = ad;
          end else begin
            rn = an * bd + bn * ad; rd = ad * bd;
          end
          sign_fix(rn, rd);
        end
        OP_MUL: begin
          rn = an * bn; rd = ad * bd;
          sign_fix(rn, rd);
        end
        OP_DIV: begin
          if (bn == 0) st = ST_DIVZ;
          else begin
            rn = an * bd; rd = ad * bn;
            sign_fix(rn, rd);
          end
        end
        OP_INC: begin
          rn = an + ad; rd = ad;
        end
        OP_SIMP: begin
          if (an != 0) begin
            x = mag(an); y = mag(ad);
            while (y != 0) begin
              r = x % y; x = y; y = r;
            end
            g = x;
            q = mag(an) / g; rn = an[WIDTH-1] ? -q : q;
            q = mag(ad) / g; rd = ad[WIDTH-1] ? -q : q;
          end
        end
        OP_EQ: eq = (an == bn) && (ad == bd);
        default: ;
      endcase
      if (st == ST_OK && rd == 0) st = ST_ZDEN;
    end
    if (st != ST_OK) begin
      rn = 0; rd = 0; eq = 1'b0;
    end
    o.res_num = rn; o.res_den = rd; o.is_equal = eq; o.status = st;
    return o;
  endfunction

  // Result checker: every strobe must match the oldest expected result.
  always @(posedge clk) begin
    rau_out_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.res_num !== want.res_num) begin
          $display("%0t: res_num exp %0d got %0d", $time, want.res_num, out_data.res_num);
          errors++;
        end
        if (out_data.res_den !== want.res_den) begin
          $display("%0t: res_den exp %0d got %0d", $time, want.res_den, out_data.res_den);
          errors++;
        end
        if (out_data.is_equal !== want.is_equal) begin
          $display("%0t: is_equal exp %0b got %0b", $time, want.is_equal,
                   out_data.is_equal);
          errors++;
        end
        if (out_data.status !== want.status) begin
          $display("%0t: status exp %0d got %0d", $time, want.status, out_data.status);
          errors++;
        end
      end
    end
  end

  function automatic rau_in_t mk(logic [2:0] op, word_t an, word_t ad, word_t bn, word_t bd);
    rau_in_t r;
    r.req_type = op; r.a_num = an; r.a_den = ad; r.b_num = bn; r.b_den = bd;
    return r;
  endfunction

  function automatic rau_out_t res(word_t n, word_t d, logic e, logic [1:0] s);
    rau_out_t r;
    r.res_num = n; r.res_den = d; r.is_equal = e; r.status = s;
    return r;
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 20);
      1: return -$signed($urandom_range(1, 20));
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic word_t rand_den();
    return ($urandom_range(0, 15) == 0) ? 0 : rand_word();
  endfunction

  // Present one item: wait until busy is low at an edge. start stays high
  // after the accept; the caller drops it only when a gap follows.
  task automatic send_item(rau_in_t req, rau_out_t want);
    start <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(want);
  endtask

  initial begin
    dir_row_t dir_rows[$];
    rau_in_t req;
    int burst;
    word_t w;
    errors = 0;
    cycle_count = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows; typed answers where obvious, predictor elsewhere.
    dir_rows.push_back('{mk(OP_ADD, 1, 3, 1, 3), 1, res(2, 3, 0, ST_OK)});
    dir_rows.push_back('{mk(OP_ADD, 1, 2, 1, 3), 0, '0});
    dir_rows.push_back('{mk(OP_SUB, 1, 2, 1, -3), 0, '0});
    dir_rows.push_back('{mk(OP_MUL, -3, 4, 5, -7), 0, '0});
    dir_rows.push_back('{mk(OP_DIV, 3, 4, 5, 7), 0, '0});
    dir_rows.push_back('{mk(OP_DIV, 3, 4, 0, 7), 1, res(0, 0, 0, ST_DIVZ)});
    dir_rows.push_back('{mk(OP_INC, 1, 2, 0, 0), 1, res(3, 2, 0, ST_OK)});
    dir_rows.push_back('{mk(OP_SIMP, 6, -8, 0, 0), 1, res(-3, 4, 0, ST_OK)});
    dir_rows.push_back('{mk(OP_SIMP, 0, 5, 0, 0), 1, res(0, 1, 0, ST_OK)});
    dir_rows.push_back('{mk(OP_EQ, 1, 2, -1, -2), 1, res(0, 1, 1, ST_OK)});
    dir_rows.push_back('{mk(OP_EQ, 1, 2, 2, 4), 1, res(0, 1, 0, ST_OK)});
    dir_rows.push_back('{mk(OP_ADD, 1, 0, 1, 2), 1, res(0, 0, 0, ST_ZDEN)});
    dir_rows.push_back('{mk(OP_MUL, 1, 2, 1, 0), 1, res(0, 0, 0, ST_ZDEN)});
    dir_rows.push_back('{mk(OP_INC, 1, 0, 0, 0), 1, res(0, 0, 0, ST_ZDEN)});
    dir_rows.push_back('{mk(OP_INC, 1, 2, 0, 0), 1, res(3, 2, 0, ST_OK)});
    // wrapped product denominator of zero
    dir_rows.push_back('{mk(OP_MUL, 1, 32'h0001_0000, 1, 32'h0001_0000), 1,
                        res(0, 0, 0, ST_ZDEN)});
    // most negative denominator stays negative
    dir_rows.push_back('{mk(OP_INC, 1, 32'h8000_0000, 0, 1), 0, '0});
    dir_rows.push_back('{mk(OP_SIMP, 32'h8000_0000, 32'h8000_0000, 0, 1), 0, '0});
    dir_rows.push_back('{mk(OP_SIMP, 32'h7fff_ffff, 32'h7fff_fffe, 0, 1), 0, '0});
    dir_rows.push_back('{mk(OP_SIMP, 32'hb2d0_5e00, 32'h7327_4a5d, 0, 1), 0, '0});
    dir_rows.push_back('{mk(OP_ADD, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1), 0, '0});
    dir_rows.push_back('{mk(OP_SUB, 32'h8000_0000, -1, -1, 32'h7fff_ffff), 0, '0});
    // unused opcode still checks the first denominator
    dir_rows.push_back('{mk(OP_UNUSED, 5, 0, 7, 0), 1, res(0, 0, 0, ST_ZDEN)});
    dir_rows.push_back('{mk(OP_EQ, -1, -1, -1, -1), 1, res(0, 1, 1, ST_OK)});
    foreach (dir_rows[i])
      send_item(dir_rows[i].req,
                dir_rows[i].typed ? dir_rows[i].ans : rational_result(dir_rows[i].req));

    // Random items in bursts separated by random gaps.
    for (int n = 0; n < NUM_RANDOM; ) begin
      burst = $urandom_range(1, 12);
      for (int k = 0; k < burst && n < NUM_RANDOM; k++, n++) begin
        req.req_type = 3'($urandom_range(0, 7));
        req.a_num = rand_word();
        req.a_den = rand_den();
        req.b_num = rand_word();
        req.b_den = rand_den();
        // equal op: often a matching pair to hit the true flag
        if (req.req_type == OP_EQ && $urandom_range(0, 2) == 0) begin
          w = $urandom_range(0, 1) ? -1 : 1;
          req.b_num = req.a_num * w;
          req.b_den = req.a_den * w;
        end
        send_item(req, rational_result(req));
      end
      if ($urandom_range(0, 2) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule

[filelist.f]
hw/rtl/rau_pkg.sv
hw/rtl/rational_arithmetic_unit.sv
tb/rational_arithmetic_unit_tb.sv
